@@ design/pfl_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and codes for the page frame fifo/lru replacer
// no dependencies
package pfl_pkg;

	localparam int NUM_FRAMES_DEF       = 64;
	localparam int PAGE_OFFSET_BITS_DEF = 12;

	localparam int ADDR_W      = 32;
	localparam int PID_W       = 5;
	localparam int FRAME_IDX_W = 6;
	localparam int CFG_COUNT_W = 7;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// register indexes, taken from paddr[2]
	localparam logic REG_POLICY      = 1'b0;
	localparam logic REG_FRAME_COUNT = 1'b1;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [CFG_COUNT_W-1:0] FRAME_COUNT_RST = CFG_COUNT_W'(64);

	typedef struct packed {
		logic [ADDR_W-1:0] virtual_address;
		logic [PID_W-1:0]  process_id;
	} req_t;

	typedef struct packed {
		logic                   page_hit;
		logic [FRAME_IDX_W-1:0] frame_index;
	} rsp_t;

	typedef struct packed {
		logic                   policy_mode;
		logic [CFG_COUNT_W-1:0] frame_count;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic resolve;
		logic commit;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

endpackage

@@ design/pfl_regs.sv @@
`timescale 1ns / 1ps
// apb configuration registers: policy mode and frame count
// depends on pfl_pkg
module pfl_regs import pfl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic                   policy_q;
	logic [CFG_COUNT_W-1:0] count_q;
	logic                   wr_en;
	logic                   reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FIFO;
			count_q  <= FRAME_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_POLICY:      policy_q <= pwdata[0];
				REG_FRAME_COUNT: count_q  <= pwdata[CFG_COUNT_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_POLICY:      prdata = APB_DATA_W'(policy_q);
			REG_FRAME_COUNT: prdata = APB_DATA_W'(count_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.policy_mode = policy_q;
	assign cfg.frame_count = count_q;

endmodule

@@ design/pfl_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer: lookup state then commit state per transaction
// depends on pfl_pkg
module pfl_ctrl import pfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd.load    = 1'b0;
		cmd.resolve = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				busy        = 1'b1;
				cmd.resolve = 1'b1;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				// next transaction may enter while this one commits
				cmd.commit = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOKUP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ design/pfl_datapath.sv @@
`timescale 1ns / 1ps
// frame table: parallel tag compare, age ranks, fill count and result register
// depends on pfl_pkg
module pfl_datapath import pfl_pkg::*; #(
	parameter int NUM_FRAMES       = NUM_FRAMES_DEF,
	parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  cfg_t cfg,
	input  req_t req,
	output rsp_t rsp,
	output logic done
);

	localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
	localparam int PAGE_W = ADDR_W - PAGE_OFFSET_BITS;
	localparam int CMP_W  = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;

	logic [PAGE_W-1:0]     page_q  [NUM_FRAMES];
	logic [PID_W-1:0]      owner_q [NUM_FRAMES];
	logic [IDX_W-1:0]      rank_q  [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] valid_q;
	logic [CNT_W-1:0]      filled_q;

	logic [PAGE_W-1:0] req_page_q;
	logic [PID_W-1:0]  req_pid_q;

	logic             hit_s1;
	logic             fill_s1;
	logic [IDX_W-1:0] sel_s1;
	logic [IDX_W-1:0] rank_s1;

	rsp_t rsp_q;
	logic done_q;

	logic [CMP_W-1:0]      count_ext;
	logic [CNT_W-1:0]      active_n;
	logic [CNT_W-1:0]      limit;
	logic [NUM_FRAMES-1:0] match;
	logic [NUM_FRAMES-1:0] match_first;
	logic [NUM_FRAMES-1:0] oldest;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      old_idx;
	logic [IDX_W-1:0]      hit_rank;
	logic                  hit;
	logic                  fill;
	logic [IDX_W-1:0]      sel;

	logic             reorder;
	logic [IDX_W-1:0] newest;

	// frames in use, clamped to 1..NUM_FRAMES
	always_comb begin
		count_ext = CMP_W'(cfg.frame_count);
		if (cfg.frame_count == '0) begin
			active_n = CNT_W'(1);
		end else if (count_ext > CMP_W'(NUM_FRAMES)) begin
			active_n = CNT_W'(NUM_FRAMES);
		end else begin
			active_n = CNT_W'(count_ext);
		end
		limit = (filled_q < active_n) ? filled_q : active_n;
	end

	always_comb begin
		for (int k = 0; k < NUM_FRAMES; k++) begin
			match[k]  = valid_q[k] && (CNT_W'(k) < limit) &&
				(page_q[k] == req_page_q) && (owner_q[k] == req_pid_q);
			oldest[k] = valid_q[k] && (rank_q[k] == '0);
		end
		// lowest matching frame wins
		match_first = match & (~match + 1'b1);
		hit_idx  = '0;
		old_idx  = '0;
		hit_rank = '0;
		for (int k = 0; k < NUM_FRAMES; k++) begin
			if (match_first[k]) begin
				hit_idx  = hit_idx | IDX_W'(k);
				hit_rank = hit_rank | rank_q[k];
			end
			if (oldest[k]) begin
				old_idx = old_idx | IDX_W'(k);
			end
		end
		hit  = |match;
		fill = !hit && (filled_q < active_n);
		if (hit) begin
			sel = hit_idx;
		end else if (fill) begin
			sel = IDX_W'(filled_q);
		end else begin
			sel = old_idx;
		end
	end

	always_comb begin
		reorder = hit_s1 ? (cfg.policy_mode == POLICY_LRU) : !fill_s1;
		newest  = fill_s1 ? IDX_W'(filled_q) : IDX_W'(filled_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			filled_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && fill_s1) begin
				valid_q[sel_s1] <= 1'b1;
				filled_q        <= filled_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_page_q <= req.virtual_address[ADDR_W-1:PAGE_OFFSET_BITS];
			req_pid_q  <= req.process_id;
		end
		if (cmd.resolve) begin
			hit_s1  <= hit;
			fill_s1 <= fill;
			sel_s1  <= sel;
			// a replaced frame is always the oldest, rank zero
			rank_s1 <= hit ? hit_rank : '0;
		end
		if (cmd.commit) begin
			if (!hit_s1) begin
				page_q[sel_s1]  <= req_page_q;
				owner_q[sel_s1] <= req_pid_q;
			end
			if (reorder) begin
				for (int k = 0; k < NUM_FRAMES; k++) begin
					if (valid_q[k] && (rank_q[k] > rank_s1)) begin
						rank_q[k] <= rank_q[k] - 1'b1;
					end
				end
			end
			if (reorder || fill_s1) begin
				rank_q[sel_s1] <= newest;
			end
			rsp_q.page_hit    <= hit_s1;
			rsp_q.frame_index <= FRAME_IDX_W'(sel_s1);
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

@@ design/page_frame_fifo_lru_replacer_top.sv @@
`timescale 1ns / 1ps
// top level of the page frame fifo/lru replacer
// depends on pfl_pkg, pfl_regs, pfl_ctrl, pfl_datapath
//
//   channel   handshake              payload         notes
//   request   start && !busy         req (req_t)     one lookup per transaction
//   result    done, one cycle        rsp (rsp_t)     receiver cannot stall
//   config    psel&penable&pwrite    pwdata/paddr    pready tied high
//
// a transaction has a lookup step (tag compare over all frames,
// pick of hit, free or oldest frame) then a commit step (table and rank update)
// a new start is taken during the commit step; done rises in the cycle after it
// reset clears the valid marks and the fill count at once, no clearing pass
module page_frame_fifo_lru_replacer_top import pfl_pkg::*; #(
	parameter int NUM_FRAMES       = NUM_FRAMES_DEF,
	parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t cfg;
	cmd_t cmd;

	pfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	pfl_datapath #(
		.NUM_FRAMES       (NUM_FRAMES),
		.PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp),
		.done   (done)
	);

endmodule
